FILE: sv/clne_pkg.sv
package clne_pkg;

  // default display geometry and queue size
  localparam int LINE_LENGTH_DEF = 40;
  localparam int LINE_COUNT_DEF  = 2;
  localparam int QUEUE_DEPTH     = 4;

  // action codes
  localparam logic [2:0] ACT_RAW_CMD  = 3'd0;
  localparam logic [2:0] ACT_RAW_DATA = 3'd1;
  localparam logic [2:0] ACT_CHAR     = 3'd2;
  localparam logic [2:0] ACT_GOTO     = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;
  localparam logic [2:0] ACT_DISPLAY  = 3'd5;
  localparam logic [2:0] ACT_INIT     = 3'd6;

  // controller command bytes
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;

  // register select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // one classified command: optional lone lead nibble, then one to three bytes
  typedef struct packed {
    logic            lead;
    logic [1:0]      nbytes;
    logic [2:0]      rs;
    logic [2:0][7:0] data;
  } job_t;

  // ddram start address of each display line
  function automatic logic [6:0] row_base(input logic [1:0] r);
    logic [6:0] base;
    unique case (r)
      2'd0: base = 7'h00;
      2'd1: base = 7'h40;
      2'd2: base = 7'h14;
      2'd3: base = 7'h54;
      default: base = 7'h00;
    endcase
    return base;
  endfunction

  // set-ddram command for a cursor position, address wraps at 7 bits
  function automatic logic [7:0] ddram_cmd(input logic [5:0] col, input logic [1:0] r);
    logic [6:0] addr;
    addr = row_base(r) + {1'b0, col};
    return CMD_DDRAM | {1'b0, addr};
  endfunction

endpackage

FILE: sv/clne_if.sv
// command words into the engine
interface clne_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_code;
  logic [5:0] column;
  logic [1:0] row;
  logic       display_enable;

  modport source (output valid, action, char_code, column, row, display_enable,
                  input ready);
  modport sink   (input valid, action, char_code, column, row, display_enable,
                  output ready);
endinterface

// nibble transfers toward the lcd bus driver
interface clne_bus_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       register_select;
  logic       last_transfer;

  modport source (output valid, nibble, register_select, last_transfer, input ready);
  modport sink   (input valid, nibble, register_select, last_transfer, output ready);
endinterface

FILE: sv/clne_front.sv
module clne_front #(
  parameter int LINE_LENGTH = clne_pkg::LINE_LENGTH_DEF,
  parameter int LINE_COUNT  = clne_pkg::LINE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  clne_cmd_if.sink          cmd,
  input  logic              full,
  output logic              push,
  output clne_pkg::job_t    job
);

  logic [5:0] cursor_column;
  logic [1:0] cursor_row;
  logic [5:0] cursor_column_next;
  logic [1:0] cursor_row_next;
  logic       accept;
  logic [6:0] col_inc;
  logic [2:0] row_inc;
  logic       line_wrap;
  logic [1:0] wrap_row;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && cmd.ready;
  assign push      = accept && (cmd.action <= clne_pkg::ACT_INIT);

  // cursor advance for a tracked character
  assign col_inc   = {1'b0, cursor_column} + 7'd1;
  assign line_wrap = col_inc >= 7'(LINE_LENGTH);
  assign row_inc   = {1'b0, cursor_row} + 3'd1;
  assign wrap_row  = (row_inc >= 3'(LINE_COUNT)) ? 2'd0 : row_inc[1:0];

  // classify the word into bytes to send and the new cursor
  always_comb begin
    job                = '0;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    unique case (cmd.action)
      clne_pkg::ACT_RAW_CMD: begin
        job.nbytes  = 2'd1;
        job.rs[0]   = clne_pkg::RS_CMD;
        job.data[0] = cmd.char_code;
      end
      clne_pkg::ACT_RAW_DATA: begin
        job.nbytes  = 2'd1;
        job.rs[0]   = clne_pkg::RS_DATA;
        job.data[0] = cmd.char_code;
      end
      clne_pkg::ACT_CHAR: begin
        job.rs[0]   = clne_pkg::RS_DATA;
        job.data[0] = cmd.char_code;
        if (line_wrap) begin
          job.nbytes         = 2'd2;
          job.rs[1]          = clne_pkg::RS_CMD;
          job.data[1]        = clne_pkg::ddram_cmd(6'd0, wrap_row);
          cursor_column_next = 6'd0;
          cursor_row_next    = wrap_row;
        end else begin
          job.nbytes         = 2'd1;
          cursor_column_next = col_inc[5:0];
        end
      end
      clne_pkg::ACT_GOTO: begin
        job.nbytes         = 2'd1;
        job.rs[0]          = clne_pkg::RS_CMD;
        job.data[0]        = clne_pkg::ddram_cmd(cmd.column, cmd.row);
        cursor_column_next = cmd.column;
        cursor_row_next    = cmd.row;
      end
      clne_pkg::ACT_CLEAR: begin
        job.nbytes         = 2'd1;
        job.rs[0]          = clne_pkg::RS_CMD;
        job.data[0]        = clne_pkg::CMD_CLEAR;
        cursor_column_next = 6'd0;
        cursor_row_next    = 2'd0;
      end
      clne_pkg::ACT_DISPLAY: begin
        job.nbytes  = 2'd1;
        job.rs[0]   = clne_pkg::RS_CMD;
        job.data[0] = cmd.display_enable ? clne_pkg::CMD_DISP_ON : clne_pkg::CMD_DISP_OFF;
      end
      clne_pkg::ACT_INIT: begin
        job.lead           = 1'b1;
        job.nbytes         = 2'd3;
        job.rs             = {3{clne_pkg::RS_CMD}};
        job.data[0]        = clne_pkg::CMD_FUNC_SET;
        job.data[1]        = clne_pkg::CMD_DISP_ON;
        job.data[2]        = clne_pkg::CMD_ENTRY;
        cursor_column_next = 6'd0;
        cursor_row_next    = 2'd0;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // cursor register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 6'd0;
      cursor_row    <= 2'd0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

FILE: sv/clne_queue.sv
module clne_queue #(
  parameter int DEPTH = clne_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clne_pkg::job_t    wdata,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output clne_pkg::job_t    rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clne_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = count == CW'(DEPTH);
  assign avail = count != '0;
  assign rdata = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: sv/clne_back.sv
module clne_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  clne_pkg::job_t    job,
  output logic              pop,
  clne_bus_if.source        bus
);

  logic [2:0] idx;
  logic [2:0] total;
  logic [2:0] k;
  logic       last;
  logic       fire;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [3:0] nib;
  logic       nib_rs;

  // nibble count of the head job and position within it
  assign total = {2'b00, job.lead} + {job.nbytes, 1'b0};
  assign last  = idx == total - 3'd1;
  assign k     = idx - {2'b00, job.lead};
  assign fire  = avail && (!bus.valid || bus.ready);
  assign pop   = fire && last;

  // pick the byte, then the half, high half first
  always_comb begin
    unique case (k[2:1])
      2'd0: begin
        cur_byte = job.data[0];
        cur_rs   = job.rs[0];
      end
      2'd1: begin
        cur_byte = job.data[1];
        cur_rs   = job.rs[1];
      end
      2'd2: begin
        cur_byte = job.data[2];
        cur_rs   = job.rs[2];
      end
      default: begin
        cur_byte = job.data[0];
        cur_rs   = job.rs[0];
      end
    endcase
    if (job.lead && idx == 3'd0) begin
      nib    = clne_pkg::CMD_FUNC_SET[7:4];
      nib_rs = clne_pkg::RS_CMD;
    end else begin
      nib    = k[0] ? cur_byte[3:0] : cur_byte[7:4];
      nib_rs = cur_rs;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (fire) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      bus.valid <= 1'b0;
    end else if (fire) begin
      bus.valid <= 1'b1;
    end else if (bus.ready) begin
      bus.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bus.nibble          <= nib;
      bus.register_select <= nib_rs;
      bus.last_transfer   <= last;
    end
  end

endmodule

FILE: sv/char_lcd_nibble_command_engine_top.sv
// a taken word goes into the queue; its first nibble is then registered in the output stage
// throughput: one nibble per cycle from the output stage while words wait and the bus is ready;
//   2 nibbles a word, 4 for a wrapping tracked char, 7 for init, so the bus side sets the rate
// a queue of QUEUE_DEPTH classified words lets the front take words while nibbles drain
// reset: synchronous, clears the cursor to column 0 row 0, empties the queue and output stage
module char_lcd_nibble_command_engine_top #(
  parameter int LINE_LENGTH = clne_pkg::LINE_LENGTH_DEF,
  parameter int LINE_COUNT  = clne_pkg::LINE_COUNT_DEF,
  parameter int QUEUE_DEPTH = clne_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  clne_cmd_if.sink   cmd,
  clne_bus_if.source bus
);

  clne_pkg::job_t push_job;
  clne_pkg::job_t head_job;
  logic           push;
  logic           full;
  logic           pop;
  logic           avail;

  // classify words and track the cursor
  clne_front #(
    .LINE_LENGTH (LINE_LENGTH),
    .LINE_COUNT  (LINE_COUNT)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  // decoupling queue
  clne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .full  (full),
    .pop   (pop),
    .avail (avail),
    .rdata (head_job)
  );

  // nibble sequencer
  clne_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .job   (head_job),
    .pop   (pop),
    .bus   (bus)
  );

endmodule

FILE: tb/tb_char_lcd_nibble_command_engine_top.sv
`timescale 1ns / 100ps

module tb_char_lcd_nibble_command_engine_top;

  localparam int LINE_LENGTH      = clne_pkg::LINE_LENGTH_DEF;
  localparam int LINE_COUNT       = clne_pkg::LINE_COUNT_DEF;
  localparam int RESET_CYCLES     = 12;
  localparam int RANDOM_PER_PHASE = 46;
  localparam int DRAIN_CYCLES     = 16;
  localparam int MAX_REPORTS      = 40;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [6:0] LINE_START [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] code;
    logic [5:0] col;
    logic [1:0] row;
    logic       en;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       last;
  } xfer_t;

  // directed row: n of zero means the nibbles come from the predictor
  typedef struct packed {
    cmd_word_t   w;
    logic [2:0]  n;
    logic [27:0] nibs;
    logic [6:0]  rs;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clne_cmd_if cmd_if ();
  clne_bus_if bus_if ();

  char_lcd_nibble_command_engine_top i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .bus (bus_if)
  );

  always #5 clk = ~clk;

  // cursor copy and the nibbles staged for the word being expanded
  logic [5:0] cursor_col;
  logic [1:0] cursor_row;
  xfer_t      staged_xfers [7];
  int         n_staged;

  xfer_t      pending_xfers [$];
  dir_row_t   directed_rows [$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  function automatic void stage_nibble(input logic [3:0] nib, input logic rs);
    staged_xfers[n_staged] = '{nibble: nib, rs: rs, last: 1'b0};
    n_staged++;
  endfunction

  function automatic void stage_byte(input logic [7:0] b, input logic rs);
    stage_nibble(b[7:4], rs);
    stage_nibble(b[3:0], rs);
  endfunction

  // address wraps at 7 bits, so a line start plus column above 7'h7F folds around
  function automatic logic [7:0] set_ddram(input logic [5:0] col, input logic [1:0] row);
    logic [6:0] addr;
    addr = LINE_START[row] + {1'b0, col};
    return clne_pkg::CMD_DDRAM | {1'b0, addr};
  endfunction

  // expand one command word into bus nibbles and move the cursor
  function automatic void expand_word(input cmd_word_t w);
    logic [6:0] next_col;
    int         next_row;
    n_staged = 0;
    unique case (w.action)
      clne_pkg::ACT_RAW_CMD:  stage_byte(w.code, clne_pkg::RS_CMD);
      clne_pkg::ACT_RAW_DATA: stage_byte(w.code, clne_pkg::RS_DATA);
      clne_pkg::ACT_CHAR: begin
        next_col = {1'b0, cursor_col} + 7'd1;
        stage_byte(w.code, clne_pkg::RS_DATA);
        if (next_col >= LINE_LENGTH) begin
          next_row = int'(cursor_row) + 1;
          if (next_row >= LINE_COUNT) next_row = 0;
          cursor_col = '0;
          cursor_row = 2'(next_row);
          stage_byte(set_ddram(6'd0, cursor_row), clne_pkg::RS_CMD);
        end else begin
          cursor_col = next_col[5:0];
        end
      end
      clne_pkg::ACT_GOTO: begin
        stage_byte(set_ddram(w.col, w.row), clne_pkg::RS_CMD);
        cursor_col = w.col;
        cursor_row = w.row;
      end
      clne_pkg::ACT_CLEAR: begin
        stage_byte(clne_pkg::CMD_CLEAR, clne_pkg::RS_CMD);
        cursor_col = '0;
        cursor_row = '0;
      end
      clne_pkg::ACT_DISPLAY:
        stage_byte(w.en ? clne_pkg::CMD_DISP_ON : clne_pkg::CMD_DISP_OFF, clne_pkg::RS_CMD);
      clne_pkg::ACT_INIT: begin
        stage_nibble(clne_pkg::CMD_FUNC_SET[7:4], clne_pkg::RS_CMD);
        stage_byte(clne_pkg::CMD_FUNC_SET, clne_pkg::RS_CMD);
        stage_byte(clne_pkg::CMD_DISP_ON, clne_pkg::RS_CMD);
        stage_byte(clne_pkg::CMD_ENTRY, clne_pkg::RS_CMD);
        cursor_col = '0;
        cursor_row = '0;
      end
      default: ;
    endcase
    if (n_staged > 0) staged_xfers[n_staged-1].last = 1'b1;
  endfunction

  function automatic void add_row(input logic [2:0] action, input logic [7:0] code,
                                  input logic [5:0] col, input logic [1:0] row,
                                  input logic en, input logic [2:0] n,
                                  input logic [27:0] nibs, input logic [6:0] rs);
    dir_row_t r;
    r.w    = '{action: action, code: code, col: col, row: row, en: en};
    r.n    = n;
    r.nibs = nibs;
    r.rs   = rs;
    directed_rows.push_back(r);
  endfunction

  // weighted toward tracked chars and gotos near the line end so wraps happen often
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        pick;
    w.code = 8'($urandom);
    w.row  = 2'($urandom);
    w.en   = 1'($urandom);
    w.col  = 6'($urandom);
    pick   = $urandom_range(99);
    if (pick < 42)      w.action = clne_pkg::ACT_CHAR;
    else if (pick < 57) begin
      w.action = clne_pkg::ACT_GOTO;
      if ($urandom_range(1)) w.col = 6'($urandom_range(39, 34));
    end
    else if (pick < 65) w.action = clne_pkg::ACT_RAW_CMD;
    else if (pick < 73) w.action = clne_pkg::ACT_RAW_DATA;
    else if (pick < 80) w.action = clne_pkg::ACT_DISPLAY;
    else if (pick < 86) w.action = clne_pkg::ACT_CLEAR;
    else if (pick < 91) w.action = clne_pkg::ACT_INIT;
    else if (pick < 95) w.action = ACT_UNUSED;
    else                w.action = clne_pkg::ACT_CHAR;
    return w;
  endfunction

  // offer one word, record its nibbles when taken, then maybe go idle
  task automatic send_word(input cmd_word_t w, input logic [2:0] n,
                           input logic [27:0] nibs, input logic [6:0] rs);
    cmd_if.valid          <= 1'b1;
    cmd_if.action         <= w.action;
    cmd_if.char_code      <= w.code;
    cmd_if.column         <= w.col;
    cmd_if.row            <= w.row;
    cmd_if.display_enable <= w.en;
    do @(posedge clk); while (!cmd_if.ready);
    expand_word(w);
    if (n > 0) begin
      for (int k = 0; k < n; k++)
        pending_xfers.push_back('{nibble: nibs[4*(n-1-k) +: 4], rs: rs[n-1-k],
                                  last: (k == n - 1)});
    end else begin
      for (int k = 0; k < n_staged; k++) pending_xfers.push_back(staged_xfers[k]);
    end
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // bus side: random stalls and check of each nibble taken
  always @(posedge clk) begin
    xfer_t exp_x;
    if (rst) begin
      bus_if.ready <= 1'b0;
    end else begin
      if (bus_if.valid && bus_if.ready) begin
        if (pending_xfers.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected word nibble=%h rs=%b last=%b", $realtime,
                     bus_if.nibble, bus_if.register_select, bus_if.last_transfer);
        end else begin
          exp_x = pending_xfers.pop_front();
          if (bus_if.nibble !== exp_x.nibble || bus_if.register_select !== exp_x.rs ||
              bus_if.last_transfer !== exp_x.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected nibble=%h rs=%b last=%b, got nibble=%h rs=%b last=%b",
                       $realtime, exp_x.nibble, exp_x.rs, exp_x.last, bus_if.nibble,
                       bus_if.register_select, bus_if.last_transfer);
          end
        end
      end
      bus_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int sent;
    cmd_word_t w;
    cmd_if.valid          = 1'b0;
    cmd_if.action         = clne_pkg::ACT_RAW_CMD;
    cmd_if.char_code      = '0;
    cmd_if.column         = '0;
    cmd_if.row            = '0;
    cmd_if.display_enable = 1'b0;
    cursor_col            = '0;
    cursor_row            = '0;

    // action, code, column, row, enable, count, nibbles, register selects
    add_row(clne_pkg::ACT_CLEAR,    8'h00, 6'd0,  2'd0, 1'b0, 2, 28'h01,      7'b00);
    add_row(clne_pkg::ACT_INIT,     8'hFF, 6'd63, 2'd3, 1'b1, 7, 28'h2280C06, 7'b0000000);
    add_row(clne_pkg::ACT_RAW_CMD,  8'h00, 6'd0,  2'd0, 1'b0, 2, 28'h00,      7'b00);
    add_row(clne_pkg::ACT_RAW_CMD,  8'hFF, 6'd63, 2'd3, 1'b1, 2, 28'hFF,      7'b00);
    add_row(clne_pkg::ACT_RAW_DATA, 8'h00, 6'd0,  2'd0, 1'b0, 2, 28'h00,      7'b11);
    add_row(clne_pkg::ACT_RAW_DATA, 8'hFF, 6'd63, 2'd3, 1'b1, 2, 28'hFF,      7'b11);
    add_row(clne_pkg::ACT_RAW_DATA, 8'hA5, 6'd21, 2'd2, 1'b0, 2, 28'hA5,      7'b11);
    add_row(clne_pkg::ACT_DISPLAY,  8'h00, 6'd0,  2'd0, 1'b1, 2, 28'h0C,      7'b00);
    add_row(clne_pkg::ACT_DISPLAY,  8'hFF, 6'd63, 2'd3, 1'b0, 2, 28'h08,      7'b00);
    // unused action code gives nothing
    add_row(ACT_UNUSED,             8'hFF, 6'd63, 2'd3, 1'b1, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_GOTO,     8'h00, 6'd0,  2'd0, 1'b0, 2, 28'h80,      7'b00);
    // column past the line end: address folds at 7 bits
    add_row(clne_pkg::ACT_GOTO,     8'h00, 6'd63, 2'd3, 1'b0, 2, 28'h93,      7'b00);
    add_row(clne_pkg::ACT_CHAR,     8'h41, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_GOTO,     8'h00, 6'd39, 2'd3, 1'b0, 2, 28'hFB,      7'b00);
    // row past the line count wraps to row 0
    add_row(clne_pkg::ACT_CHAR,     8'h7E, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_GOTO,     8'h00, 6'd38, 2'd1, 1'b0, 2, 28'hE6,      7'b00);
    add_row(clne_pkg::ACT_CHAR,     8'h00, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_CHAR,     8'hFF, 6'd63, 2'd3, 1'b1, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_GOTO,     8'h00, 6'd39, 2'd0, 1'b0, 2, 28'hA7,      7'b00);
    add_row(clne_pkg::ACT_CHAR,     8'h55, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_GOTO,     8'h00, 6'd39, 2'd2, 1'b0, 2, 28'hBB,      7'b00);
    add_row(clne_pkg::ACT_CHAR,     8'hAA, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_CHAR,     8'h20, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);
    add_row(clne_pkg::ACT_INIT,     8'h00, 6'd0,  2'd0, 1'b0, 7, 28'h2280C06, 7'b0000000);
    add_row(clne_pkg::ACT_CHAR,     8'h30, 6'd0,  2'd0, 1'b0, 0, 28'h0,       7'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].n, directed_rows[i].nibs,
                directed_rows[i].rs);

    // random words across idle and stall phases
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        w = random_word();
        send_word(w, 3'd0, 28'h0, 7'b0);
        if (w.action != ACT_UNUSED) sent++;
      end
    end
    cmd_if.valid <= 1'b0;

    // drain, then watch for stray words
    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_xfers.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
sv/clne_pkg.sv
sv/clne_if.sv
sv/clne_front.sv
sv/clne_queue.sv
sv/clne_back.sv
sv/char_lcd_nibble_command_engine_top.sv
tb/tb_char_lcd_nibble_command_engine_top.sv
